@@ rtl/ppw_pkg.sv @@
// Package for the particle propagate-and-weight block.
// Holds the transaction types, fixed-point constants, pipeline stage indexes and helpers.
// No dependencies.
package ppw_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int NUM_DIM = 2;

    localparam int SUM_W   = DATA_W + 2;
    localparam int TQ_W    = 13;
    localparam int PROD_W  = DATA_W + TQ_W + 1;
    localparam int TENTH_W = PROD_W - FRAC_W;
    localparam int MAG_W   = DATA_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int MSB_W   = 6;
    localparam int MANT_W  = 31;
    localparam int RSQ_W   = 2 * MANT_W;
    localparam int K_W     = 6;
    localparam int LOG_W   = K_W + FRAC_W;
    localparam int S_W     = LOG_W + 1;
    localparam int S11_W   = S_W + 4;
    localparam int WP_W    = S11_W + 32;
    localparam int W_W     = WP_W - 33;
    localparam int ROUNDS  = FRAC_W;

    localparam logic                      KIND_INIT = 1'b0;
    localparam logic                      KIND_MOVE = 1'b1;

    localparam logic [TQ_W-1:0]           TENTH_Q    = 13'd6554;
    localparam logic signed [PROD_W-1:0]  TENTH_HALF = PROD_W'(32768);
    localparam logic [31:0]               LN2_Q32    = 32'd2977044472;
    localparam logic [WP_W-1:0]           W_HALF     = WP_W'(64'h1_0000_0000);
    localparam logic [SQ_W-1:0]           Z_ONE      = 64'h0000_0001_0000_0000;
    localparam logic [SQ_W-1:0]           Z_ONE_BIG  = 64'h0000_0000_1000_0000;
    localparam logic [MSB_W-1:0]          MANT_TOP   = 6'd30;
    localparam logic [K_W-1:0]            K_BASE     = 6'd32;
    localparam logic [K_W-1:0]            K_BASE_BIG = 6'd28;
    localparam logic [K_W-1:0]            K_MAX      = 6'd35;
    localparam logic [MSB_W-1:0]          MSB_MIN    = 6'd32;

    localparam logic signed [DATA_W-1:0]  SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0]  SAT_MIN = 32'sh8000_0000;

    localparam int ST_MUL   = 0;
    localparam int ST_SUM   = 1;
    localparam int ST_DIFF  = 2;
    localparam int ST_SQ    = 3;
    localparam int ST_Z     = 4;
    localparam int ST_MSB   = 5;
    localparam int ST_NORM  = 6;
    localparam int ST_S11   = ST_NORM + ROUNDS + 1;
    localparam int ST_PROD  = ST_S11 + 1;
    localparam int ST_OUT   = ST_PROD + 1;
    localparam int NUM_ST   = ST_OUT + 1;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] noise_pos_x;
        logic signed [DATA_W-1:0] noise_pos_y;
        logic signed [DATA_W-1:0] noise_vel_x;
        logic signed [DATA_W-1:0] noise_vel_y;
        logic signed [DATA_W-1:0] obs_x;
        logic signed [DATA_W-1:0] obs_y;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
        logic signed [DATA_W-1:0] log_weight;
    } out_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
            r = v[DATA_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = SAT_MIN;
        end else begin
            r = SAT_MAX;
        end
        return r;
    endfunction

    function automatic logic [MSB_W-1:0] msb_pos(input logic [SQ_W-1:0] z);
        logic [MSB_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < SQ_W; i++) begin
            if (z[i]) begin
                pos = MSB_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/particle_propagate_and_weight.sv @@
// Top level of the particle propagate-and-weight block: full datapath in one pipeline.
// Depends on ppw_pkg for the transaction types, constants and helpers.
//
// This block takes one particle transaction per clock unless a stalled output has backed the pipeline up
// to its input, and returns one result per particle, in order. The pipeline depth is set by the log2 unit
// of each coordinate: one register stage per fraction bit, each stage a 31x31 squaring, plus the
// propagate, difference, square, normalize and scaling stages.
// A stalled output only holds the stages that are full; empty stages keep filling.
module particle_propagate_and_weight (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ppw_pkg::in_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output ppw_pkg::out_t out_data
);
    import ppw_pkg::*;

    logic [NUM_ST-1:0] v_reg;
    logic [NUM_ST-1:0] v_next;
    logic [NUM_ST-1:0] en;

    in_t                      in_reg;
    logic signed [PROD_W-1:0] tprod_reg [NUM_DIM];

    logic signed [PROD_W-1:0]  trnd    [NUM_DIM];
    logic signed [TENTH_W-1:0] tenth   [NUM_DIM];
    logic signed [SUM_W-1:0]   psum    [NUM_DIM];
    logic signed [SUM_W-1:0]   vsum    [NUM_DIM];
    logic signed [DATA_W-1:0]  cur_pos [NUM_DIM];
    logic signed [DATA_W-1:0]  cur_vel [NUM_DIM];
    logic signed [DATA_W-1:0]  n_pos   [NUM_DIM];
    logic signed [DATA_W-1:0]  n_vel   [NUM_DIM];
    state_t                    st_next;
    state_t                    st_reg  [ST_SUM:ST_PROD];
    logic signed [DATA_W-1:0]  obs_reg [NUM_DIM];

    logic signed [DATA_W-1:0]  res_pos [NUM_DIM];
    logic signed [DATA_W:0]    diff    [NUM_DIM];
    logic signed [DATA_W:0]    diff_n  [NUM_DIM];
    logic [MAG_W-1:0]          mag_reg [NUM_DIM];
    logic [SQ_W-1:0]           d2_reg  [NUM_DIM];

    logic                      big     [NUM_DIM];
    logic [SQ_W-1:0]           d2s     [NUM_DIM];
    logic [SQ_W-1:0]           z_reg   [NUM_DIM];
    logic                      big_reg [NUM_DIM];
    logic [SQ_W-1:0]           zn_reg  [NUM_DIM];
    logic                      bign_reg[NUM_DIM];
    logic [MSB_W-1:0]          msb_reg [NUM_DIM];
    logic [SQ_W-1:0]           zsh     [NUM_DIM];

    logic [MANT_W-1:0]         m_reg    [ROUNDS+1][NUM_DIM];
    logic [FRAC_W-1:0]         frac_reg [ROUNDS+1][NUM_DIM];
    logic [K_W-1:0]            k_reg    [ROUNDS+1][NUM_DIM];

    logic [S_W-1:0]            s_sum;
    logic [S11_W-1:0]          s11_reg;
    logic [WP_W-1:0]           prod_reg;
    logic [WP_W-1:0]           wsum;
    out_t                      out_reg;

    logic in_fire;
    logic out_fire;

    // A stage loads when it is empty or when the stage after it loads.
    always_comb
    begin
        en[NUM_ST-1] = !v_reg[NUM_ST-1] || out_ready;
        for (int i = NUM_ST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NUM_ST; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[ST_OUT];
    assign out_data  = out_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            in_reg       <= in_data;
            tprod_reg[0] <= $signed(in_data.vel_x) * $signed({1'b0, TENTH_Q});
            tprod_reg[1] <= $signed(in_data.vel_y) * $signed({1'b0, TENTH_Q});
        end
    end

    assign cur_pos[0] = in_reg.pos_x;
    assign cur_pos[1] = in_reg.pos_y;
    assign cur_vel[0] = in_reg.vel_x;
    assign cur_vel[1] = in_reg.vel_y;
    assign n_pos[0]   = in_reg.noise_pos_x;
    assign n_pos[1]   = in_reg.noise_pos_y;
    assign n_vel[0]   = in_reg.noise_vel_x;
    assign n_vel[1]   = in_reg.noise_vel_y;

    always_comb
    begin
        for (int d = 0; d < NUM_DIM; d++)
        begin
            trnd[d]  = tprod_reg[d] + TENTH_HALF;
            tenth[d] = trnd[d][PROD_W-1:FRAC_W];
            psum[d]  = {{2{cur_pos[d][DATA_W-1]}}, cur_pos[d]}
                     + {{2{n_pos[d][DATA_W-1]}}, n_pos[d]}
                     + {{(SUM_W-TENTH_W){tenth[d][TENTH_W-1]}}, tenth[d]};
            vsum[d]  = {{2{cur_vel[d][DATA_W-1]}}, cur_vel[d]}
                     + {{2{n_vel[d][DATA_W-1]}}, n_vel[d]};
        end
        if (in_reg.kind == KIND_MOVE)
        begin
            st_next.pos_x = sat_w(psum[0]);
            st_next.pos_y = sat_w(psum[1]);
            st_next.vel_x = sat_w(vsum[0]);
            st_next.vel_y = sat_w(vsum[1]);
        end
        else
        begin
            st_next.pos_x = n_pos[0];
            st_next.pos_y = n_pos[1];
            st_next.vel_x = n_vel[0];
            st_next.vel_y = n_vel[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            st_reg[ST_SUM] <= st_next;
            obs_reg[0]     <= in_reg.obs_x;
            obs_reg[1]     <= in_reg.obs_y;
        end
    end

    for (genvar s = ST_DIFF; s <= ST_PROD; s++)
    begin : g_state
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                st_reg[s] <= st_reg[s-1];
            end
        end
    end

    assign res_pos[0] = st_reg[ST_SUM].pos_x;
    assign res_pos[1] = st_reg[ST_SUM].pos_y;

    for (genvar d = 0; d < NUM_DIM; d++)
    begin : g_dim
        assign diff[d]   = {res_pos[d][DATA_W-1], res_pos[d]}
                         - {obs_reg[d][DATA_W-1], obs_reg[d]};
        assign diff_n[d] = -diff[d];
        assign big[d]    = |d2_reg[d][SQ_W-1:SQ_W-4];
        assign d2s[d]    = big[d] ? {4'b0, d2_reg[d][SQ_W-1:4]} : d2_reg[d];
        assign zsh[d]    = zn_reg[d] >> (msb_reg[d] - MANT_TOP);

        always_ff @(posedge clk)
        begin
            if (en[ST_DIFF])
            begin
                mag_reg[d] <= diff[d][DATA_W] ? diff_n[d][MAG_W-1:0] : diff[d][MAG_W-1:0];
            end
            if (en[ST_SQ])
            begin
                d2_reg[d] <= mag_reg[d] * mag_reg[d];
            end
            if (en[ST_Z])
            begin
                z_reg[d]   <= (d2s[d] << 3) + (d2s[d] << 1) + (big[d] ? Z_ONE_BIG : Z_ONE);
                big_reg[d] <= big[d];
            end
            if (en[ST_MSB])
            begin
                msb_reg[d]  <= msb_pos(z_reg[d]);
                zn_reg[d]   <= z_reg[d];
                bign_reg[d] <= big_reg[d];
            end
            if (en[ST_NORM])
            begin
                m_reg[0][d]    <= zsh[d][MANT_W-1:0];
                frac_reg[0][d] <= '0;
                k_reg[0][d]    <= msb_reg[d] - (bign_reg[d] ? K_BASE_BIG : K_BASE);
            end
        end

        // Each round squares the Q1.30 mantissa and yields one fraction bit of log2.
        for (genvar r = 1; r <= ROUNDS; r++)
        begin : g_round
            logic [RSQ_W-1:0] sq;
            logic [MANT_W:0]  t;

            assign sq = m_reg[r-1][d] * m_reg[r-1][d];
            assign t  = sq[RSQ_W-1:MANT_W-1];

            always_ff @(posedge clk)
            begin
                if (en[ST_NORM+r])
                begin
                    m_reg[r][d]    <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
                    frac_reg[r][d] <= {frac_reg[r-1][d][FRAC_W-2:0], t[MANT_W]};
                    k_reg[r][d]    <= k_reg[r-1][d];
                end
            end
        end
    end

    assign s_sum = S_W'({k_reg[ROUNDS][0], frac_reg[ROUNDS][0]})
                 + S_W'({k_reg[ROUNDS][1], frac_reg[ROUNDS][1]});
    assign wsum  = prod_reg + W_HALF;

    always_ff @(posedge clk)
    begin
        if (en[ST_S11])
        begin
            s11_reg <= (S11_W'(s_sum) << 3) + (S11_W'(s_sum) << 1) + S11_W'(s_sum);
        end
        if (en[ST_PROD])
        begin
            prod_reg <= s11_reg * LN2_Q32;
        end
        if (en[ST_OUT])
        begin
            out_reg.new_pos_x  <= st_reg[ST_PROD].pos_x;
            out_reg.new_pos_y  <= st_reg[ST_PROD].pos_y;
            out_reg.new_vel_x  <= st_reg[ST_PROD].vel_x;
            out_reg.new_vel_y  <= st_reg[ST_PROD].vel_y;
            out_reg.log_weight <= DATA_W'(0) - {{(DATA_W-W_W){1'b0}}, wsum[WP_W-1:33]};
        end
    end

`ifndef SYNTHESIS
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(v_reg) == $past($countones(v_reg))
                 + ($past(in_fire) ? 1 : 0) - ($past(out_fire) ? 1 : 0))
        else $error("pipeline occupancy does not match accepted transactions");

    a_msb_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_MSB] |-> (msb_reg[0] >= MSB_MIN) && (msb_reg[1] >= MSB_MIN))
        else $error("log2 argument below one");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_NORM] |-> (k_reg[0][0] <= K_MAX) && (k_reg[0][1] <= K_MAX))
        else $error("log2 integer part out of range");

    a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_NORM+ROUNDS] |-> m_reg[ROUNDS][0][MANT_W-1] && m_reg[ROUNDS][1][MANT_W-1])
        else $error("log2 mantissa lost normalization");
`endif

endmodule
